// File: rtl/gmc_pkg.sv
// ----------------------------------------------------------------------------
// gmc_pkg
// Shared types, codes and the saturating add helper of the global minimum cut block.
// ----------------------------------------------------------------------------
package gmc_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_VERTEX_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INITIAL_BOUND = 2'd1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_RUN   = 1'b1;

  localparam logic [4:0]  VERTEX_COUNT_RESET  = 5'd16;
  localparam logic [31:0] INITIAL_BOUND_RESET = 32'hFFFF_FFFF;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_PHASE_INIT,
    OP_PHASE_NEXT,
    OP_SCAN,
    OP_ATT_START,
    OP_ATT_RD,
    OP_ATT_WR,
    OP_GRP_RD,
    OP_GRP_WR,
    OP_MRG_RS,
    OP_MRG_RP,
    OP_MRG_WP,
    OP_MRG_RQ,
    OP_MRG_WQ,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic last_i;       // loop index is at the last vertex in use
    logic last_step;    // current step is the last one of the phase
    logic found;        // the scan has seen an eligible vertex
    logic phases_done;  // no further phase is needed
    logic out_busy;     // a result still waits to be taken
  } status_t;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// File: rtl/gmc_ctrl.sv
// ----------------------------------------------------------------------------
// gmc_ctrl
// Sequencer of the minimum cut phases: scan, attach update, group merge and
// matrix merge, issuing one datapath operation per cycle.
// ----------------------------------------------------------------------------
module gmc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_accept,
  input  logic             command,
  input  gmc_pkg::status_t status,
  output gmc_pkg::cmd_t    cmd,
  output logic             in_stall
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_PHASE  = 15'b000000000000010,
    S_SCAN   = 15'b000000000000100,
    S_PICK   = 15'b000000000001000,
    S_ATT_RD = 15'b000000000010000,
    S_ATT_WR = 15'b000000000100000,
    S_GRP_RD = 15'b000000001000000,
    S_GRP_WR = 15'b000000010000000,
    S_MRG_RS = 15'b000000100000000,
    S_MRG_RP = 15'b000001000000000,
    S_MRG_WP = 15'b000010000000000,
    S_MRG_RQ = 15'b000100000000000,
    S_MRG_WQ = 15'b001000000000000,
    S_FINISH = 15'b010000000000000,
    S_SPARE  = 15'b100000000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE) || (status.out_busy && command);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = gmc_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (command == gmc_pkg::CMD_RUN) begin
            cmd.op     = gmc_pkg::OP_INIT;
            state_next = S_PHASE;
          end else begin
            cmd.op = gmc_pkg::OP_LOAD;
          end
        end
      end
      S_PHASE: begin
        if (status.phases_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.op     = gmc_pkg::OP_PHASE_INIT;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = gmc_pkg::OP_SCAN;
        if (status.last_i) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (!status.found) begin
          cmd.op     = gmc_pkg::OP_PHASE_NEXT;
          state_next = S_PHASE;
        end else if (status.last_step) begin
          cmd.op     = gmc_pkg::OP_GRP_RD;
          state_next = S_GRP_WR;
        end else begin
          cmd.op     = gmc_pkg::OP_ATT_START;
          state_next = S_ATT_RD;
        end
      end
      S_ATT_RD: begin
        cmd.op     = gmc_pkg::OP_ATT_RD;
        state_next = S_ATT_WR;
      end
      S_ATT_WR: begin
        cmd.op     = gmc_pkg::OP_ATT_WR;
        state_next = status.last_i ? S_SCAN : S_ATT_RD;
      end
      S_GRP_RD: begin
        cmd.op     = gmc_pkg::OP_GRP_RD;
        state_next = S_GRP_WR;
      end
      S_GRP_WR: begin
        cmd.op     = gmc_pkg::OP_GRP_WR;
        state_next = S_MRG_RS;
      end
      S_MRG_RS: begin
        cmd.op     = gmc_pkg::OP_MRG_RS;
        state_next = S_MRG_RP;
      end
      S_MRG_RP: begin
        cmd.op     = gmc_pkg::OP_MRG_RP;
        state_next = S_MRG_WP;
      end
      S_MRG_WP: begin
        cmd.op     = gmc_pkg::OP_MRG_WP;
        state_next = S_MRG_RQ;
      end
      S_MRG_RQ: begin
        cmd.op     = gmc_pkg::OP_MRG_RQ;
        state_next = S_MRG_WQ;
      end
      S_MRG_WQ: begin
        cmd.op     = gmc_pkg::OP_MRG_WQ;
        state_next = status.last_i ? S_PHASE : S_MRG_RS;
      end
      S_FINISH: begin
        cmd.op     = gmc_pkg::OP_FINISH;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/gmc_datapath.sv
// ----------------------------------------------------------------------------
// gmc_datapath
// Weight matrix memory, per-vertex attachment weights, vertex flags, group
// masks, best cut record, configuration registers and result register.
// ----------------------------------------------------------------------------
module gmc_datapath #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gmc_pkg::cmd_t                       cmd,
  output gmc_pkg::status_t                    status,
  input  logic                                cfg_we,
  input  logic [gmc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [gmc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic [3:0]                          row_vertex,
  input  logic [3:0]                          col_vertex,
  input  logic [15:0]                         edge_weight,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [31:0]                         cut_weight,
  output logic [15:0]                         cut_mask
);

  localparam int VIDX   = $clog2(MAX_VERTICES);
  localparam int CW     = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W = 2 * VIDX;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam logic [31:0] WMASK =
    (WEIGHT_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << WEIGHT_BITS) - 64'd1);

  // Configuration registers.
  logic [4:0]  vertex_count;
  logic [31:0] initial_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= gmc_pkg::VERTEX_COUNT_RESET;
      initial_bound <= gmc_pkg::INITIAL_BOUND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gmc_pkg::CFG_VERTEX_COUNT:  vertex_count  <= cfg_data[4:0];
        gmc_pkg::CFG_INITIAL_BOUND: initial_bound <= cfg_data;
        default: ;
      endcase
    end
  end

  // Run state.
  logic [CW-1:0]           n_eff;
  logic [CW-1:0]           phase;
  logic [CW-1:0]           step;
  logic [VIDX-1:0]         i;
  logic [VIDX-1:0]         s;
  logic [VIDX-1:0]         p;
  logic                    found;
  logic [31:0]             best_att;
  logic [31:0]             ws;
  logic [31:0]             attach [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] in_phase;
  logic [MAX_VERTICES-1:0] merged;
  logic [MAX_VERTICES-1:0] groups [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] gtmp;
  logic [31:0]             best_weight;
  logic [MAX_VERTICES-1:0] best_mask;

  // Matrix memory.
  logic [31:0]       mem [DEPTH];
  logic [31:0]       rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [31:0]       wdata;

  logic [VIDX-1:0] row_idx;
  logic [VIDX-1:0] col_idx;
  logic            idx_ok;
  logic [CW-1:0]   n_sat;
  logic [31:0]     att_i;
  logic            elig;
  logic [VIDX-1:0] gsel;
  logic [15:0]     mask16;

  assign row_idx = VIDX'(row_vertex);
  assign col_idx = VIDX'(col_vertex);
  assign idx_ok  = (32'(row_vertex) < MAX_VERTICES) && (32'(col_vertex) < MAX_VERTICES);
  assign n_sat   = (32'(vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                      : CW'(vertex_count);
  assign att_i   = attach[i];
  assign elig    = !merged[i] && !in_phase[i];
  assign gsel    = (cmd.op == gmc_pkg::OP_GRP_WR) ? p : s;

  assign status.last_i      = (CW'(i) == (n_eff - CW'(1)));
  assign status.last_step   = ((CW + 1)'(step) + (CW + 1)'(phase) + (CW + 1)'(1))
                              == (CW + 1)'(n_eff);
  assign status.found       = found;
  assign status.phases_done = ((CW + 1)'(phase) + (CW + 1)'(1)) >= (CW + 1)'(n_eff);
  assign status.out_busy    = out_valid;

  always_comb begin
    mem_we = 1'b0;
    waddr  = {p, i};
    wdata  = gmc_pkg::sat_add(rdata, ws);
    raddr  = {s, i};
    case (cmd.op)
      gmc_pkg::OP_LOAD: begin
        mem_we = idx_ok;
        waddr  = {row_idx, col_idx};
        wdata  = {16'b0, edge_weight} & WMASK;
      end
      gmc_pkg::OP_MRG_WP: begin
        mem_we = 1'b1;
      end
      gmc_pkg::OP_MRG_WQ: begin
        mem_we = 1'b1;
        waddr  = {i, p};
      end
      gmc_pkg::OP_MRG_RP: raddr = {p, i};
      gmc_pkg::OP_MRG_RQ: raddr = {i, p};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      gmc_pkg::OP_INIT: begin
        n_eff       <= n_sat;
        merged      <= '0;
        best_weight <= initial_bound;
        best_mask   <= '0;
        p           <= '0;
        phase       <= '0;
        for (int v = 0; v < MAX_VERTICES; v++) begin
          groups[v] <= MAX_VERTICES'(1) << v;
        end
      end
      gmc_pkg::OP_PHASE_INIT: begin
        in_phase <= '0;
        step     <= '0;
        i        <= '0;
        found    <= 1'b0;
        for (int v = 0; v < MAX_VERTICES; v++) begin
          attach[v] <= '0;
        end
      end
      gmc_pkg::OP_PHASE_NEXT: begin
        phase <= phase + CW'(1);
      end
      gmc_pkg::OP_SCAN: begin
        if (elig && (!found || (att_i > best_att))) begin
          s        <= i;
          best_att <= att_i;
          found    <= 1'b1;
        end
        i <= status.last_i ? '0 : i + VIDX'(1);
      end
      gmc_pkg::OP_ATT_START: begin
        in_phase[s] <= 1'b1;
        p           <= s;
        i           <= '0;
      end
      gmc_pkg::OP_ATT_WR: begin
        attach[i] <= gmc_pkg::sat_add(att_i, rdata);
        if (status.last_i) begin
          i     <= '0;
          found <= 1'b0;
          step  <= step + CW'(1);
        end else begin
          i <= i + VIDX'(1);
        end
      end
      gmc_pkg::OP_GRP_RD: begin
        gtmp <= groups[gsel];
        if (best_att < best_weight) begin
          best_weight <= best_att;
          best_mask   <= groups[gsel];
        end
      end
      gmc_pkg::OP_GRP_WR: begin
        groups[p] <= groups[gsel] | gtmp;
        i         <= '0;
      end
      gmc_pkg::OP_MRG_RP: begin
        ws <= rdata;
      end
      gmc_pkg::OP_MRG_WQ: begin
        if (status.last_i) begin
          merged[s] <= 1'b1;
          phase     <= phase + CW'(1);
        end else begin
          i <= i + VIDX'(1);
        end
      end
      default: ;
    endcase
  end

  // Vertices beyond the array read as zero in the result mask.
  for (genvar b = 0; b < 16; b++) begin : g_mask
    if (b < MAX_VERTICES) begin : g_in
      assign mask16[b] = best_mask[b];
    end else begin : g_out
      assign mask16[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == gmc_pkg::OP_FINISH) begin
      cut_weight <= best_weight;
      cut_mask   <= mask16;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == gmc_pkg::OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/global_min_cut.sv
// ----------------------------------------------------------------------------
// global_min_cut
// Stoer-Wagner minimum cut over a dense weight matrix held in on-chip memory.
// ----------------------------------------------------------------------------
// A weight write is accepted every cycle while idle.
// The length of a run is set by the scan, attach and merge loops over the weight memory.
// The result waits in an output register; a new run waits until it is taken.
// Synchronous reset restores the configuration registers and idles the block;
// the weight matrix is not cleared.
module global_min_cut #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [gmc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [gmc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               command,
  input  logic [3:0]                         row_vertex,
  input  logic [3:0]                         col_vertex,
  input  logic [15:0]                        edge_weight,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [31:0]                        cut_weight,
  output logic [15:0]                        cut_mask
);

  gmc_pkg::cmd_t    cmd;
  gmc_pkg::status_t status;
  logic             in_accept;

  assign in_accept = in_valid && !in_stall;

  gmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .command   (command),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  gmc_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .row_vertex  (row_vertex),
    .col_vertex  (col_vertex),
    .edge_weight (edge_weight),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cut_weight  (cut_weight),
    .cut_mask    (cut_mask)
  );

endmodule

// File: rtl/gmc_checker.sv
// ----------------------------------------------------------------------------
// gmc_port_props
// Port-level checks of the minimum cut block, bound to the top level.
// ----------------------------------------------------------------------------
module gmc_port_props (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        command,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] cut_weight,
  input logic [15:0] cut_mask
);

  // A run transaction occupies the block in the following cycle.
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && command) |=> in_stall)
    else $error("block accepted input right after a run transaction");

  // A result only appears at the end of a busy period.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a preceding run");

  // A waiting result holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(cut_weight) && $stable(cut_mask)))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind global_min_cut gmc_port_props u_gmc_port_props (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .command    (command),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .cut_weight (cut_weight),
  .cut_mask   (cut_mask)
);
